[design/acr_pkg.sv]
// Shared types and constants for the ARP cache and responder.
// No dependencies; used by acr_table and arp_cache_responder_top.
package acr_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int OP_W       = 16;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HIT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LEARNED = 3'd4;

    localparam logic [OP_W-1:0] OP_REQ  = 16'd1;
    localparam logic [OP_W-1:0] OP_RPLY = 16'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MY_IP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MY_MAC = 2'd1;

    localparam logic [IP_W-1:0]  BCAST_IP  = '1;
    localparam logic [MAC_W-1:0] BCAST_MAC = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MRD,
        ST_MCHK,
        ST_UPD,
        ST_FIN
    } acr_state_t;

    typedef struct packed {
        logic ip_we;
        logic mac_we;
    } acr_wr_t;

endpackage

[design/acr_table.sv]
// Address table: per-entry valid bits plus IP and MAC memories with registered reads.
// Entry 0 reads as broadcast until written. Depends on acr_pkg.
module acr_table
    import acr_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    localparam int IW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IW-1:0]    ip_raddr,
    input  logic [IW-1:0]    mac_raddr,
    input  acr_wr_t          wr,
    input  logic [IW-1:0]    wr_idx,
    input  logic [IP_W-1:0]  wr_ip,
    input  logic [MAC_W-1:0] wr_mac,
    output logic             rd_valid,
    output logic [IP_W-1:0]  rd_ip,
    output logic [MAC_W-1:0] rd_mac
);

    logic [IP_W-1:0]  ip_mem  [DEPTH];
    logic [MAC_W-1:0] mac_mem [DEPTH];

    logic [DEPTH-1:0] valid_reg, valid_next;
    logic             ip0_dflt_reg, ip0_dflt_next;
    logic             mac0_dflt_reg, mac0_dflt_next;
    logic             rd_valid_reg;
    logic             rd_ip0_reg;
    logic             rd_mac0_reg;
    logic [IP_W-1:0]  rd_ip_reg;
    logic [MAC_W-1:0] rd_mac_reg;

    always_comb
    begin
        valid_next     = valid_reg;
        ip0_dflt_next  = ip0_dflt_reg;
        mac0_dflt_next = mac0_dflt_reg;
        if (wr.ip_we)
        begin
            valid_next = valid_reg | (DEPTH'(1) << wr_idx);
            if (wr_idx == '0)
            begin
                ip0_dflt_next = 1'b0;
            end
        end
        if (wr.mac_we && (wr_idx == '0))
        begin
            mac0_dflt_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= DEPTH'(1);
            ip0_dflt_reg  <= 1'b1;
            mac0_dflt_reg <= 1'b1;
            rd_valid_reg  <= 1'b0;
            rd_ip0_reg    <= 1'b0;
            rd_mac0_reg   <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            ip0_dflt_reg  <= ip0_dflt_next;
            mac0_dflt_reg <= mac0_dflt_next;
            rd_valid_reg  <= valid_reg[ip_raddr];
            rd_ip0_reg    <= (ip_raddr == '0) && ip0_dflt_reg;
            rd_mac0_reg   <= (mac_raddr == '0) && mac0_dflt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.ip_we)
        begin
            ip_mem[wr_idx] <= wr_ip;
        end
        if (wr.mac_we)
        begin
            mac_mem[wr_idx] <= wr_mac;
        end
        rd_ip_reg  <= ip_mem[ip_raddr];
        rd_mac_reg <= mac_mem[mac_raddr];
    end

    assign rd_valid = rd_valid_reg;
    assign rd_ip    = rd_ip0_reg  ? BCAST_IP  : rd_ip_reg;
    assign rd_mac   = rd_mac0_reg ? BCAST_MAC : rd_mac_reg;

endmodule

[design/arp_cache_responder_top.sv]
// ARP cache and responder: top level with sequencer, config registers and output register.
// Timing: ARP requests for us and ignored packets go from accept straight to the result state;
// table lookups scan one entry per cycle through the table read port. One request in flight;
// the next is accepted once the result is registered.
// Reset: my_ip and my_mac clear, entry 0 maps broadcast IP to broadcast MAC, other entries
// invalid; no clearing pass.
module arp_cache_responder_top
    import acr_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  logic [OP_W-1:0]       opcode,
    input  logic [MAC_W-1:0]      sender_mac,
    input  logic [IP_W-1:0]       sender_ip,
    input  logic [MAC_W-1:0]      target_mac,
    input  logic [IP_W-1:0]       target_ip,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KIND_W-1:0]     kind,
    output logic [OP_W-1:0]       frame_opcode,
    output logic [MAC_W-1:0]      frame_dest_mac,
    output logic [MAC_W-1:0]      frame_target_mac,
    output logic [IP_W-1:0]       frame_target_ip,
    output logic [MAC_W-1:0]      resolved_mac,
    output logic                  table_full
);

    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IW + 1;

    acr_state_t state_reg, state_next;

    logic [IP_W-1:0]   my_ip_reg;
    logic [MAC_W-1:0]  my_mac_reg;

    logic              learn_reg, learn_next;
    logic [MAC_W-1:0]  s_mac_reg, s_mac_next;
    logic [IP_W-1:0]   s_ip_reg, s_ip_next;
    logic [IP_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     found_idx_reg, found_idx_next;
    logic              free_reg, free_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [KIND_W-1:0] rk_reg, rk_next;
    logic              rfull_reg, rfull_next;
    logic [MAC_W-1:0]  rres_reg, rres_next;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [OP_W-1:0]   fop_reg, fop_next;
    logic [MAC_W-1:0]  fdst_reg, fdst_next;
    logic [MAC_W-1:0]  ftmac_reg, ftmac_next;
    logic [IP_W-1:0]   ftip_reg, ftip_next;
    logic [MAC_W-1:0]  res_mac_reg, res_mac_next;
    logic              full_reg, full_next;

    acr_wr_t           wr;
    logic [IW-1:0]     wr_idx;
    logic [IP_W-1:0]   wr_ip;
    logic [MAC_W-1:0]  wr_mac;
    logic              rd_valid;
    logic [IP_W-1:0]   rd_ip;
    logic [MAC_W-1:0]  rd_mac;

    logic              req_me;
    logic              rpl_me;
    logic              iss_more;
    logic              scan_hit;
    logic              scan_last;
    logic              out_free;

    acr_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ip_raddr  (iss_reg[IW-1:0]),
        .mac_raddr (found_idx_reg),
        .wr        (wr),
        .wr_idx    (wr_idx),
        .wr_ip     (wr_ip),
        .wr_mac    (wr_mac),
        .rd_valid  (rd_valid),
        .rd_ip     (rd_ip),
        .rd_mac    (rd_mac)
    );

    assign req_me    = !cmd && (opcode == OP_REQ) && (target_ip == my_ip_reg);
    assign rpl_me    = !cmd && (opcode == OP_RPLY) && (target_mac == my_mac_reg);
    assign iss_more  = iss_reg < CNT_W'(TABLE_DEPTH);
    assign scan_hit  = cmp_vld_reg && rd_valid && (rd_ip == key_reg);
    assign scan_last = cmp_vld_reg && (cmp_idx_reg == IW'(TABLE_DEPTH - 1));
    assign out_free  = !out_valid_reg || !out_stall;

    assign wr_idx = found_reg ? found_idx_reg : free_idx_reg;
    assign wr_ip  = key_reg;
    assign wr_mac = learn_reg ? s_mac_reg : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (cmd || rpl_me) ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = learn_reg ? ST_UPD : ST_MRD;
                end
                else if (scan_last)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_MRD:  state_next = ST_MCHK;
            ST_MCHK: state_next = ST_FIN;
            ST_UPD:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        learn_next     = learn_reg;
        s_mac_next     = s_mac_reg;
        s_ip_next      = s_ip_reg;
        key_next       = key_reg;
        iss_next       = iss_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        rk_next        = rk_reg;
        rfull_next     = rfull_reg;
        rres_next      = rres_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        fop_next       = fop_reg;
        fdst_next      = fdst_reg;
        ftmac_next     = ftmac_reg;
        ftip_next      = ftip_reg;
        res_mac_next   = res_mac_reg;
        full_next      = full_reg;
        wr             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    learn_next = !cmd;
                    s_mac_next = sender_mac;
                    s_ip_next  = sender_ip;
                    key_next   = cmd ? target_ip : sender_ip;
                    iss_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    rfull_next = 1'b0;
                    rres_next  = '0;
                    rk_next    = req_me ? KIND_REPLY : KIND_NONE;
                end
            end
            ST_SCAN:
            begin
                if (iss_more)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                cmp_vld_next = iss_more;
                cmp_idx_next = iss_reg[IW-1:0];
                if (scan_hit)
                begin
                    found_next     = 1'b1;
                    found_idx_next = cmp_idx_reg;
                end
                else if (cmp_vld_reg && !rd_valid && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = cmp_idx_reg;
                end
            end
            ST_MRD:
            begin
            end
            ST_MCHK:
            begin
                if (rd_mac != '0)
                begin
                    rk_next   = KIND_HIT;
                    rres_next = rd_mac;
                end
                else
                begin
                    rk_next = KIND_REQUEST;
                end
            end
            ST_UPD:
            begin
                if (learn_reg)
                begin
                    if (found_reg)
                    begin
                        wr.mac_we = 1'b1;
                        rk_next   = KIND_LEARNED;
                    end
                    else if (free_reg)
                    begin
                        wr.ip_we  = 1'b1;
                        wr.mac_we = 1'b1;
                        rk_next   = KIND_LEARNED;
                    end
                    else
                    begin
                        rk_next    = KIND_NONE;
                        rfull_next = 1'b1;
                    end
                end
                else
                begin
                    rk_next = KIND_REQUEST;
                    if (free_reg)
                    begin
                        wr.ip_we  = 1'b1;
                        wr.mac_we = 1'b1;
                    end
                    else
                    begin
                        rfull_next = 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = rk_reg;
                    res_mac_next   = rres_reg;
                    full_next      = rfull_reg;
                    fop_next       = '0;
                    fdst_next      = '0;
                    ftmac_next     = '0;
                    ftip_next      = '0;
                    if (rk_reg == KIND_REPLY)
                    begin
                        fop_next   = OP_RPLY;
                        fdst_next  = s_mac_reg;
                        ftmac_next = s_mac_reg;
                        ftip_next  = s_ip_reg;
                    end
                    else if (rk_reg == KIND_REQUEST)
                    begin
                        fop_next   = OP_REQ;
                        fdst_next  = BCAST_MAC;
                        ftip_next  = key_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            my_ip_reg     <= '0;
            my_mac_reg    <= '0;
            iss_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MY_IP:  my_ip_reg  <= cfg_data[IP_W-1:0];
                    CFG_MY_MAC: my_mac_reg <= cfg_data[MAC_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        learn_reg     <= learn_next;
        s_mac_reg     <= s_mac_next;
        s_ip_reg      <= s_ip_next;
        key_reg       <= key_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        rk_reg        <= rk_next;
        rfull_reg     <= rfull_next;
        rres_reg      <= rres_next;
        kind_reg      <= kind_next;
        fop_reg       <= fop_next;
        fdst_reg      <= fdst_next;
        ftmac_reg     <= ftmac_next;
        ftip_reg      <= ftip_next;
        res_mac_reg   <= res_mac_next;
        full_reg      <= full_next;
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign frame_opcode     = fop_reg;
    assign frame_dest_mac   = fdst_reg;
    assign frame_target_mac = ftmac_reg;
    assign frame_target_ip  = ftip_reg;
    assign resolved_mac     = res_mac_reg;
    assign table_full       = full_reg;

endmodule

[sim/tb_arp_cache_responder_top.sv]
// Testbench for arp_cache_responder_top: directed and random ARP packets and resolve queries.
// Its own table model predicts every result, and the results are checked field by field.
// Depends on acr_pkg and arp_cache_responder_top.
`timescale 1ns / 1ps

module tb_arp_cache_responder_top;
    import acr_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int POOL_N = 24;
    localparam int PHASE_ITEMS = 280;
    localparam int DRAIN_CYCLES = 2 * (DEPTH + 4);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [OP_W-1:0]   opcode;
        logic [MAC_W-1:0]  smac;
        logic [IP_W-1:0]   sip;
        logic [MAC_W-1:0]  tmac;
        logic [IP_W-1:0]   tip;
    } arp_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OP_W-1:0]   fop;
        logic [MAC_W-1:0]  fdst;
        logic [MAC_W-1:0]  ftmac;
        logic [IP_W-1:0]   ftip;
        logic [MAC_W-1:0]  rmac;
        logic              full;
    } arp_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  cmd = 1'b0;
    logic [OP_W-1:0]       opcode = '0;
    logic [MAC_W-1:0]      sender_mac = '0;
    logic [IP_W-1:0]       sender_ip = '0;
    logic [MAC_W-1:0]      target_mac = '0;
    logic [IP_W-1:0]       target_ip = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [KIND_W-1:0]     kind;
    logic [OP_W-1:0]       frame_opcode;
    logic [MAC_W-1:0]      frame_dest_mac;
    logic [MAC_W-1:0]      frame_target_mac;
    logic [IP_W-1:0]       frame_target_ip;
    logic [MAC_W-1:0]      resolved_mac;
    logic                  table_full;

    arp_req_t    req_q[$];
    arp_result_t exp_results[$];

    logic              tbl_valid [DEPTH];
    logic [IP_W-1:0]   tbl_ip [DEPTH];
    logic [MAC_W-1:0]  tbl_mac [DEPTH];
    logic [IP_W-1:0]   own_ip = '0;
    logic [MAC_W-1:0]  own_mac = '0;
    logic [IP_W-1:0]   ip_pool [POOL_N];

    int send_idle_pct = 0;
    int rx_stall_pct = 0;
    int mismatch_cnt = 0;

    arp_cache_responder_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .opcode           (opcode),
        .sender_mac       (sender_mac),
        .sender_ip        (sender_ip),
        .target_mac       (target_mac),
        .target_ip        (target_ip),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .frame_opcode     (frame_opcode),
        .frame_dest_mac   (frame_dest_mac),
        .frame_target_mac (frame_target_mac),
        .frame_target_ip  (frame_target_ip),
        .resolved_mac     (resolved_mac),
        .table_full       (table_full)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("tb_arp_cache_responder_top: FAIL");
        $finish;
    end

    function automatic logic [MAC_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[MAC_W-1:0];
    endfunction

    function automatic logic [IP_W-1:0] pick_ip();
        return ip_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    function automatic arp_req_t mk_req(logic c, logic [OP_W-1:0] op, logic [MAC_W-1:0] smac,
                                        logic [IP_W-1:0] sip, logic [MAC_W-1:0] tmac,
                                        logic [IP_W-1:0] tip);
        arp_req_t r;
        r.cmd = c;
        r.opcode = op;
        r.smac = smac;
        r.sip = sip;
        r.tmac = tmac;
        r.tip = tip;
        return r;
    endfunction

    function automatic int find_ip(logic [IP_W-1:0] ip);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_ip[i] == ip)
                return i;
        return -1;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < DEPTH; i++)
            if (!tbl_valid[i])
                return i;
        return -1;
    endfunction

    // Table update and expected result for one accepted request.
    function automatic arp_result_t predict_arp(arp_req_t r);
        arp_result_t res;
        int e;
        res = '0;
        if (r.cmd == 1'b0)
        begin
            if (r.opcode == OP_REQ && r.tip == own_ip)
            begin
                res.kind = KIND_REPLY;
                res.fop = OP_RPLY;
                res.fdst = r.smac;
                res.ftmac = r.smac;
                res.ftip = r.sip;
            end
            else if (r.opcode == OP_RPLY && r.tmac == own_mac)
            begin
                e = find_ip(r.sip);
                if (e < 0)
                begin
                    e = first_free();
                    if (e >= 0)
                    begin
                        tbl_valid[e] = 1'b1;
                        tbl_ip[e] = r.sip;
                    end
                end
                if (e >= 0)
                begin
                    tbl_mac[e] = r.smac;
                    res.kind = KIND_LEARNED;
                end
                else
                    res.full = 1'b1;
            end
        end
        else
        begin
            e = find_ip(r.tip);
            if (e >= 0 && tbl_mac[e] != '0)
            begin
                res.kind = KIND_HIT;
                res.rmac = tbl_mac[e];
            end
            else
            begin
                res.kind = KIND_REQUEST;
                res.fop = OP_REQ;
                res.fdst = BCAST_MAC;
                res.ftip = r.tip;
                if (e < 0)
                begin
                    e = first_free();
                    if (e >= 0)
                    begin
                        tbl_valid[e] = 1'b1;
                        tbl_ip[e] = r.tip;
                        tbl_mac[e] = '0;
                    end
                    else
                        res.full = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Mostly well-formed traffic aimed at our addresses and a small IP pool; the rest is noise.
    function automatic arp_req_t random_req(output bit noise);
        arp_req_t r;
        int sel;
        r = mk_req(1'b0, OP_W'($urandom), rand48(), $urandom, rand48(), $urandom);
        noise = 1'b0;
        sel = $urandom_range(0, 99);
        if (sel < 28)
        begin
            r.cmd = 1'b1;
            if ($urandom_range(0, 99) < 85)
                r.tip = pick_ip();
        end
        else if (sel < 58)
        begin
            r.opcode = OP_RPLY;
            if ($urandom_range(0, 99) < 85)
                r.tmac = own_mac;
            if ($urandom_range(0, 99) < 85)
                r.sip = pick_ip();
            if ($urandom_range(0, 99) < 10)
                r.smac = '0;
        end
        else if (sel < 85)
        begin
            r.opcode = OP_REQ;
            if ($urandom_range(0, 99) < 75)
                r.tip = own_ip;
        end
        else
            noise = (r.opcode != OP_REQ && r.opcode != OP_RPLY);
        return r;
    endfunction

    task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == CFG_MY_IP)
            own_ip = data[IP_W-1:0];
        else if (idx == CFG_MY_MAC)
            own_mac = data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // sampled mid-cycle so the driver and monitor have settled
    task automatic wait_drained();
        while (req_q.size() != 0 || in_valid || exp_results.size() != 0)
            @(negedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                exp_results.push_back(predict_arp(mk_req(cmd, opcode, sender_mac, sender_ip,
                                                          target_mac, target_ip)));
            if (!in_valid || !in_stall)
            begin
                if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    arp_req_t r;
                    r = req_q.pop_front();
                    in_valid <= 1'b1;
                    cmd <= r.cmd;
                    opcode <= r.opcode;
                    sender_mac <= r.smac;
                    sender_ip <= r.sip;
                    target_mac <= r.tmac;
                    target_ip <= r.tip;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (exp_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual kind %0d",
                             $time, kind);
                    mismatch_cnt++;
                end
                else
                begin
                    arp_result_t x;
                    x = exp_results.pop_front();
                    cmp_field("kind", x.kind, kind);
                    cmp_field("frame_opcode", x.fop, frame_opcode);
                    cmp_field("frame_dest_mac", x.fdst, frame_dest_mac);
                    cmp_field("frame_target_mac", x.ftmac, frame_target_mac);
                    cmp_field("frame_target_ip", x.ftip, frame_target_ip);
                    cmp_field("resolved_mac", x.rmac, resolved_mac);
                    cmp_field("table_full", x.full, table_full);
                end
            end
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    initial
    begin
        logic [IP_W-1:0]  ip_a;
        logic [IP_W-1:0]  ip_b;
        logic [IP_W-1:0]  ip_c;
        logic [MAC_W-1:0] mac_x;
        logic [MAC_W-1:0] mac_y;
        logic [CFG_DATA_W-1:0] ip_word;
        logic [CFG_DATA_W-1:0] mac_word;
        arp_req_t r;
        bit noise;
        int n;

        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_valid[i] = (i == 0);
            tbl_ip[i] = (i == 0) ? BCAST_IP : '0;
            tbl_mac[i] = (i == 0) ? BCAST_MAC : '0;
        end
        for (int i = 0; i < POOL_N - 2; i++)
            ip_pool[i] = $urandom;
        ip_pool[POOL_N - 2] = BCAST_IP;
        ip_pool[POOL_N - 1] = '0;
        ip_a = ip_pool[0];
        ip_b = ip_pool[1];
        ip_c = ip_pool[2];
        mac_x = rand48() | 48'h1;
        mac_y = rand48() | 48'h1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // registers still at reset: own IP and MAC are zero
        req_q.push_back(mk_req(1'b0, OP_REQ, BCAST_MAC, BCAST_IP, rand48(), '0));
        req_q.push_back(mk_req(1'b0, OP_RPLY, '0, ip_a, '0, $urandom));
        req_q.push_back(mk_req(1'b1, '0, '0, '0, '0, ip_a));
        req_q.push_back(mk_req(1'b1, '0, '0, '0, '0, BCAST_IP));
        wait_drained();

        write_reg(CFG_MY_IP, {16'hffff, ip_pool[5]});
        write_reg(CFG_MY_MAC, rand48());
        req_q.push_back(mk_req(1'b0, OP_REQ, '0, '0, '0, own_ip));
        req_q.push_back(mk_req(1'b0, OP_REQ, rand48(), $urandom, own_mac, ~own_ip));
        req_q.push_back(mk_req(1'b0, OP_RPLY, mac_x, ip_a, own_mac, $urandom));
        req_q.push_back(mk_req(1'b1, '0, '0, '0, '0, ip_a));
        req_q.push_back(mk_req(1'b0, OP_RPLY, rand48(), ip_b, ~own_mac, own_ip));
        req_q.push_back(mk_req(1'b0, '0, rand48(), ip_c, own_mac, own_ip));
        req_q.push_back(mk_req(1'b0, 16'd3, rand48(), ip_c, own_mac, own_ip));
        req_q.push_back(mk_req(1'b0, '1, rand48(), ip_c, own_mac, own_ip));
        req_q.push_back(mk_req(1'b1, '0, '0, '0, '0, ip_b));
        req_q.push_back(mk_req(1'b1, OP_REQ, rand48(), $urandom, rand48(), ip_b));
        req_q.push_back(mk_req(1'b0, OP_RPLY, mac_y, BCAST_IP, own_mac, '0));
        req_q.push_back(mk_req(1'b1, OP_RPLY, '0, '0, '0, BCAST_IP));
        req_q.push_back(mk_req(1'b0, OP_RPLY, rand48(), ip_c, own_mac, '1));
        req_q.push_back(mk_req(1'b1, '0, '0, '0, '0, ip_c));
        req_q.push_back(mk_req(1'b1, '1, '1, '1, '1, '0));
        req_q.push_back(mk_req(1'b0, OP_RPLY, '0, '0, own_mac, '0));
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            ip_word = {rand48()};
            mac_word = rand48();
            case (ph)
                0: begin ip_word = '1; mac_word = '1; end
                2: ip_word[IP_W-1:0] = '0;
                3: mac_word = '0;
                default: ;
            endcase
            write_reg(CFG_MY_IP, ip_word);
            write_reg(CFG_MY_MAC, mac_word);
            if (ph == 2 || ph == 4)
            begin
                write_reg(CFG_SPARE2, rand48());
                write_reg(CFG_SPARE3, rand48());
            end
            case (ph)
                1: begin send_idle_pct = 61; rx_stall_pct = 0; end
                2: begin send_idle_pct = 0; rx_stall_pct = 61; end
                3: begin send_idle_pct = 31; rx_stall_pct = 31; end
                default: begin send_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                r = random_req(noise);
                req_q.push_back(r);
                if (!noise)
                    n++;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tb_arp_cache_responder_top: PASS");
        else
            $display("tb_arp_cache_responder_top: FAIL");
        $finish;
    end

endmodule

[files.f]
design/acr_pkg.sv
design/acr_table.sv
design/arp_cache_responder_top.sv
sim/tb_arp_cache_responder_top.sv
